// ----- sv/assert_macros.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold whenever the trigger holds, in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ----- sv/krhc_pkg.sv -----
`timescale 1ns / 1ps
package krhc_pkg;

   localparam int MERSENNE_EXPONENT = 61;
   localparam int LENGTH_BITS       = 40;

   localparam int HASH_BITS      = 61;
   localparam int LEN_FIELD_BITS = 40;
   localparam int WORD_BITS      = 64;
   localparam int HALF_BITS      = WORD_BITS / 2;
   localparam int PROD_BITS      = 2 * WORD_BITS;
   localparam int FOLD_BITS      = MERSENNE_EXPONENT + 1;

   localparam logic [WORD_BITS-1:0] PRIME =
      (WORD_BITS'(1) << MERSENNE_EXPONENT) - WORD_BITS'(1);
   localparam logic [FOLD_BITS-1:0] TWICE_PRIME = {PRIME[MERSENNE_EXPONENT-1:0], 1'b0};

   // Multiplier phases: four partial products, then the fold add and the final subtract.
   localparam int PHASE_BITS = 3;
   localparam logic [PHASE_BITS-1:0] PH_FIRST  = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_FOLD   = 3'd4;
   localparam logic [PHASE_BITS-1:0] PH_FINISH = 3'd5;

   // Program addresses.
   localparam int PC_BITS = 4;
   localparam logic [PC_BITS-1:0] PC_IDLE      = 4'd0;
   localparam logic [PC_BITS-1:0] PC_RED_BASE  = 4'd1;
   localparam logic [PC_BITS-1:0] PC_RED_LEFT  = 4'd2;
   localparam logic [PC_BITS-1:0] PC_RED_RIGHT = 4'd3;
   localparam logic [PC_BITS-1:0] PC_TEST      = 4'd4;
   localparam logic [PC_BITS-1:0] PC_MUL_ACC   = 4'd5;
   localparam logic [PC_BITS-1:0] PC_SQUARE    = 4'd6;
   localparam logic [PC_BITS-1:0] PC_FINAL     = 4'd7;
   localparam logic [PC_BITS-1:0] PC_ADD       = 4'd8;
   localparam logic [PC_BITS-1:0] PC_EMIT      = 4'd9;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_MUL,
      OP_BRANCH,
      OP_ADD,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      SEL_ONE,
      SEL_SQ,
      SEL_ACC,
      SEL_LEFT,
      SEL_RIGHT
   } sel_type;

   typedef enum logic [1:0] {
      DST_SQ,
      DST_ACC,
      DST_LEFT,
      DST_RIGHT
   } dst_type;

   typedef struct packed {
      op_type             op;
      sel_type            sel_a;
      sel_type            sel_b;
      dst_type            dst;
      logic               shift_len;
      logic [PC_BITS-1:0] next_pc;
      logic [PC_BITS-1:0] zero_pc;  // branch target when no length bits remain
      logic [PC_BITS-1:0] skip_pc;  // branch target when the current length bit is clear
   } ctrl_word_type;

   function automatic ctrl_word_type make_word(op_type op, sel_type sel_a, sel_type sel_b,
                                               dst_type dst, logic shift_len,
                                               logic [PC_BITS-1:0] next_pc,
                                               logic [PC_BITS-1:0] zero_pc,
                                               logic [PC_BITS-1:0] skip_pc);
      ctrl_word_type w;
      w.op        = op;
      w.sel_a     = sel_a;
      w.sel_b     = sel_b;
      w.dst       = dst;
      w.shift_len = shift_len;
      w.next_pc   = next_pc;
      w.zero_pc   = zero_pc;
      w.skip_pc   = skip_pc;
      return w;
   endfunction

   // The control store.
   function automatic ctrl_word_type microcode(logic [PC_BITS-1:0] pc);
      ctrl_word_type w;
      case (pc)
         PC_IDLE:      w = make_word(OP_LOAD, SEL_ONE, SEL_ONE, DST_ACC, 1'b0,
                                     PC_RED_BASE, PC_IDLE, PC_IDLE);
         PC_RED_BASE:  w = make_word(OP_MUL, SEL_SQ, SEL_ONE, DST_SQ, 1'b0,
                                     PC_RED_LEFT, PC_IDLE, PC_IDLE);
         PC_RED_LEFT:  w = make_word(OP_MUL, SEL_LEFT, SEL_ONE, DST_LEFT, 1'b0,
                                     PC_RED_RIGHT, PC_IDLE, PC_IDLE);
         PC_RED_RIGHT: w = make_word(OP_MUL, SEL_RIGHT, SEL_ONE, DST_RIGHT, 1'b0,
                                     PC_TEST, PC_IDLE, PC_IDLE);
         PC_TEST:      w = make_word(OP_BRANCH, SEL_ONE, SEL_ONE, DST_ACC, 1'b0,
                                     PC_MUL_ACC, PC_FINAL, PC_SQUARE);
         PC_MUL_ACC:   w = make_word(OP_MUL, SEL_ACC, SEL_SQ, DST_ACC, 1'b0,
                                     PC_SQUARE, PC_IDLE, PC_IDLE);
         PC_SQUARE:    w = make_word(OP_MUL, SEL_SQ, SEL_SQ, DST_SQ, 1'b1,
                                     PC_TEST, PC_IDLE, PC_IDLE);
         PC_FINAL:     w = make_word(OP_MUL, SEL_LEFT, SEL_ACC, DST_ACC, 1'b0,
                                     PC_ADD, PC_IDLE, PC_IDLE);
         PC_ADD:       w = make_word(OP_ADD, SEL_ACC, SEL_RIGHT, DST_ACC, 1'b0,
                                     PC_EMIT, PC_IDLE, PC_IDLE);
         PC_EMIT:      w = make_word(OP_EMIT, SEL_ACC, SEL_ONE, DST_ACC, 1'b0,
                                     PC_IDLE, PC_IDLE, PC_IDLE);
         default:      w = make_word(OP_LOAD, SEL_ONE, SEL_ONE, DST_ACC, 1'b0,
                                     PC_RED_BASE, PC_IDLE, PC_IDLE);
      endcase
      return w;
   endfunction

endpackage

// ----- sv/karp_rabin_hash_concat_top.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   left_hash, right_hash, right_length
// rsp      out        rsp_valid/rsp_ready   joined_hash
// csr      in         csr_valid/csr_ready   data (base)
//
// An item holds the block from its transfer until the program returns to idle, and only then
// can the next one transfer. The result is loaded into the output register as the program
// returns to idle, and each modular multiply runs on one 32x32 unit.
// Reset (synchronous, active high) clears the base, program counter, phase and result flag.
// A result waiting on rsp stalls only the last program step, until the output register frees.
`include "assert_macros.svh"

module karp_rabin_hash_concat_top
   import krhc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [HASH_BITS-1:0]      req_left_hash,
   input  logic [HASH_BITS-1:0]      req_right_hash,
   input  logic [LEN_FIELD_BITS-1:0] req_right_length,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [HASH_BITS-1:0]      rsp_joined_hash,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [HASH_BITS-1:0]      csr_data
);

   // Control state.
   logic [PC_BITS-1:0]    pc_ff, pc_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [HASH_BITS-1:0]  base_ff, base_in;

   // Datapath registers. Values live in 64-bit words and stay below the prime
   // once the three reduction steps at the start of the program have run, but for the final sum.
   logic [WORD_BITS-1:0]   sq_ff, sq_in;
   logic [WORD_BITS-1:0]   acc_ff, acc_in;
   logic [WORD_BITS-1:0]   left_ff, left_in;
   logic [WORD_BITS-1:0]   right_ff, right_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [FOLD_BITS-1:0]   fold_ff, fold_in;
   logic [HASH_BITS-1:0]   out_ff, out_in;

   ctrl_word_type ctrl;

   logic [WORD_BITS-1:0]         op_a, op_b;
   logic [HALF_BITS-1:0]         a_half, b_half;
   logic [2*HALF_BITS-1:0]       pp;
   logic [PROD_BITS-1:0]         pp_shifted;
   logic [WORD_BITS-1:0]         mul_result;
   logic [MERSENNE_EXPONENT-1:0] fold_reduced;
   logic [WORD_BITS-1:0]         emit_value;
   logic                         req_xfer;
   logic                         out_free;

   assign ctrl = microcode(pc_ff);

   function automatic logic [WORD_BITS-1:0] pick(sel_type sel, logic [WORD_BITS-1:0] sq,
                                                 logic [WORD_BITS-1:0] acc,
                                                 logic [WORD_BITS-1:0] left,
                                                 logic [WORD_BITS-1:0] right);
      logic [WORD_BITS-1:0] v;
      case (sel)
         SEL_ONE:   v = WORD_BITS'(1);
         SEL_SQ:    v = sq;
         SEL_ACC:   v = acc;
         SEL_LEFT:  v = left;
         SEL_RIGHT: v = right;
         default:   v = WORD_BITS'(1);
      endcase
      return v;
   endfunction

   assign op_a = pick(ctrl.sel_a, sq_ff, acc_ff, left_ff, right_ff);
   assign op_b = pick(ctrl.sel_b, sq_ff, acc_ff, left_ff, right_ff);

   // Phase bit 1 picks the half of the first operand, bit 0 the half of the second.
   assign a_half = phase_ff[1] ? op_a[WORD_BITS-1:HALF_BITS] : op_a[HALF_BITS-1:0];
   assign b_half = phase_ff[0] ? op_b[WORD_BITS-1:HALF_BITS] : op_b[HALF_BITS-1:0];
   assign pp     = a_half * b_half;

   always_comb begin
      case (phase_ff[1:0])
         2'd0:    pp_shifted = PROD_BITS'(pp);
         2'd3:    pp_shifted = PROD_BITS'(pp) << (2 * HALF_BITS);
         default: pp_shifted = PROD_BITS'(pp) << HALF_BITS;
      endcase
   end

   // The folded sum stays below twice the prime, so one subtract completes it.
   assign fold_reduced = (fold_ff >= FOLD_BITS'(PRIME)) ?
                         MERSENNE_EXPONENT'(fold_ff - FOLD_BITS'(PRIME)) :
                         MERSENNE_EXPONENT'(fold_ff);
   assign mul_result   = WORD_BITS'(fold_reduced);

   // The final sum is below twice the prime as well.
   assign emit_value = (acc_ff >= PRIME) ? (acc_ff - PRIME) : acc_ff;

   assign req_ready = (ctrl.op == OP_LOAD);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      pc_in        = pc_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      base_in      = base_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      len_in       = len_ff;
      prod_in      = prod_ff;
      fold_in      = fold_ff;
      out_in       = out_ff;

      if (csr_valid) begin
         base_in = csr_data;
      end

      case (ctrl.op)
         OP_LOAD: begin
            if (req_xfer) begin
               left_in  = WORD_BITS'(req_left_hash);
               right_in = WORD_BITS'(req_right_hash);
               len_in   = LENGTH_BITS'(req_right_length);
               sq_in    = WORD_BITS'(base_ff);
               acc_in   = WORD_BITS'(1);
               pc_in    = ctrl.next_pc;
            end
         end
         OP_MUL: begin
            if (phase_ff == PH_FIRST) begin
               prod_in = pp_shifted;
            end else if (phase_ff < PH_FOLD) begin
               prod_in = prod_ff + pp_shifted;
            end
            if (phase_ff == PH_FOLD) begin
               fold_in = FOLD_BITS'(prod_ff[MERSENNE_EXPONENT-1:0]) +
                         FOLD_BITS'(prod_ff[2*MERSENNE_EXPONENT-1:MERSENNE_EXPONENT]);
            end
            if (phase_ff == PH_FINISH) begin
               phase_in = PH_FIRST;
               pc_in    = ctrl.next_pc;
               case (ctrl.dst)
                  DST_SQ:    sq_in    = mul_result;
                  DST_ACC:   acc_in   = mul_result;
                  DST_LEFT:  left_in  = mul_result;
                  DST_RIGHT: right_in = mul_result;
                  default:   acc_in   = mul_result;
               endcase
               if (ctrl.shift_len) begin
                  len_in = len_ff >> 1;
               end
            end else begin
               phase_in = phase_ff + PHASE_BITS'(1);
            end
         end
         OP_BRANCH: begin
            if (len_ff == '0) begin
               pc_in = ctrl.zero_pc;
            end else if (!len_ff[0]) begin
               pc_in = ctrl.skip_pc;
            end else begin
               pc_in = ctrl.next_pc;
            end
         end
         OP_ADD: begin
            acc_in = acc_ff + right_ff;
            pc_in  = ctrl.next_pc;
         end
         OP_EMIT: begin
            if (out_free) begin
               out_in       = emit_value[HASH_BITS-1:0];
               rsp_valid_in = 1'b1;
               pc_in        = ctrl.next_pc;
            end
         end
         default: begin
            pc_in = PC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_IDLE;
         phase_ff     <= PH_FIRST;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
      end else begin
         pc_ff        <= pc_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
      end
      sq_ff    <= sq_in;
      acc_ff   <= acc_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      len_ff   <= len_in;
      prod_ff  <= prod_in;
      fold_ff  <= fold_in;
      out_ff   <= out_in;
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_joined_hash = out_ff;

   // Every delivered hash is fully reduced.
   `ASSERT_IMPLIES(a_rsp_reduced, clock, reset, rsp_valid, WORD_BITS'(rsp_joined_hash) < PRIME, "result not below the prime")
   // The multiplier only runs inside a multiply step.
   `ASSERT_IMPLIES(a_phase_in_mul, clock, reset, phase_ff != PH_FIRST, ctrl.op == OP_MUL, "multiplier phase outside a multiply step")
   // One conditional subtract must be enough after the fold.
   `ASSERT_IMPLIES(a_fold_bound, clock, reset, phase_ff == PH_FINISH, fold_ff < TWICE_PRIME, "folded product not below twice the prime")
   // An accepted item always starts with the base reduction.
   `ASSERT_NEXT(a_start, clock, reset, req_valid && req_ready, pc_ff == PC_RED_BASE && phase_ff == PH_FIRST, "program did not start after a transfer")

endmodule
